// ----- rtl/ptsd_pkg.sv -----
// shared constants and types for the point to segment distance block
`default_nettype none
package ptsd_pkg;

    // default coordinate width and fraction bits of the distance
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;

    // width of the distance port
    localparam int DIST_W = 21;

    // which part of the segment is nearest
    typedef enum logic [1:0] {
        PART_A   = 2'd0,
        PART_B   = 2'd1,
        PART_MID = 2'd2
    } part_t;

endpackage
`default_nettype wire

// ----- rtl/ptsd_div_cell.sv -----
// one restoring division step for both projection coordinates
`default_nettype none
module ptsd_div_cell #(
    parameter int RW     = 34,
    parameter int QB     = 16,
    parameter int SIDE_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              v_in,
    input  wire logic [RW-2:0]     d_in,
    input  wire logic [RW-1:0]     rx_in,
    input  wire logic [QB-1:0]     nx_in,
    input  wire logic [RW-1:0]     ry_in,
    input  wire logic [QB-1:0]     ny_in,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   v_out,
    output logic [RW-2:0]          d_out,
    output logic [RW-1:0]          rx_out,
    output logic [QB-1:0]          nx_out,
    output logic [RW-1:0]          ry_out,
    output logic [QB-1:0]          ny_out,
    output logic [SIDE_W-1:0]      side_out
);

    logic [RW-1:0] tx;
    logic [RW-1:0] ty;
    logic          gex;
    logic          gey;
    logic [RW-1:0] rx_next;
    logic [RW-1:0] ry_next;

    // shift in the next numerator bit and try the subtraction
    always_comb
    begin
        tx      = {rx_in[RW-2:0], nx_in[QB-1]};
        ty      = {ry_in[RW-2:0], ny_in[QB-1]};
        gex     = (tx >= {1'b0, d_in});
        gey     = (ty >= {1'b0, d_in});
        rx_next = gex ? (tx - {1'b0, d_in}) : tx;
        ry_next = gey ? (ty - {1'b0, d_in}) : ty;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_out <= 1'b0;
        else if (en)
            v_out <= v_in;
    end

    // payload, quotient bits enter at the bottom of the numerator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_out    <= d_in;
            rx_out   <= rx_next;
            ry_out   <= ry_next;
            nx_out   <= {nx_in[QB-2:0], gex};
            ny_out   <= {ny_in[QB-2:0], gey};
            side_out <= side_in;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ptsd_sqrt_cell.sv -----
// one digit-by-digit square root step
`default_nettype none
module ptsd_sqrt_cell #(
    parameter int RB = 22
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            v_in,
    input  wire logic [RB+1:0]   rem_in,
    input  wire logic [2*RB-1:0] rad_in,
    input  wire logic [RB-1:0]   root_in,
    input  wire logic [1:0]      part_in,
    output logic                 v_out,
    output logic [RB+1:0]        rem_out,
    output logic [2*RB-1:0]      rad_out,
    output logic [RB-1:0]        root_out,
    output logic [1:0]           part_out
);

    logic [RB+1:0] tr;
    logic [RB+1:0] trial;
    logic          ge;

    // bring down two radicand bits and test root*4+1
    always_comb
    begin
        tr    = {rem_in[RB-1:0], rad_in[2*RB-1:2*RB-2]};
        trial = {root_in, 2'b01};
        ge    = (tr >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_out <= 1'b0;
        else if (en)
            v_out <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= ge ? (tr - trial) : tr;
            rad_out  <= {rad_in[2*RB-3:0], 2'b00};
            root_out <= {root_in[RB-2:0], ge};
            part_out <= part_in;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/point_to_segment_distance.sv -----
// top level: distance from a point to a segment, fully pipelined
//
//  channel  signals                              direction  width
//  request  in_valid/in_ready, six coordinates   in         COORD_BITS each
//  result   out_valid/out_ready, distance, part  out        21 / 2
//
// one request is taken per cycle while no result is held; the pipeline runs
// through the chain of division cells (one quotient bit each) and the chain of
// square root cells (one root bit each).
// reset clears only the valid bits of the stages.
// when a result waits unaccepted the whole pipeline holds.
`default_nettype none
module point_to_segment_distance #(
    parameter int COORD_BITS = ptsd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ptsd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] seg_start_x,
    input  wire logic signed [COORD_BITS-1:0] seg_start_y,
    input  wire logic signed [COORD_BITS-1:0] seg_end_x,
    input  wire logic signed [COORD_BITS-1:0] seg_end_y,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ptsd_pkg::DIST_W-1:0]       distance,
    output logic [1:0]                        nearest_part
);

    localparam int C      = COORD_BITS;
    localparam int DW     = C + 1;
    localparam int PW     = 2 * DW;
    localparam int DOT_W  = PW + 1;
    localparam int LEN_W  = 2 * C + 1;
    localparam int NW     = LEN_W + C;
    localparam int RW     = LEN_W + 1;
    localparam int SIDE_W = 6 * C + 4;
    localparam int XW     = C + 2;
    localparam int SW     = 2 * XW;
    localparam int RB     = C + 2 + FRAC_BITS;
    localparam int RAD_W  = 2 * RB;

    logic en;

    // whole pipeline moves unless a result is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // stage 1: input capture
    logic                v1_reg;
    logic signed [C-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, px1_reg, py1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= seg_start_x;
            ay1_reg <= seg_start_y;
            bx1_reg <= seg_end_x;
            by1_reg <= seg_end_y;
            px1_reg <= point_x;
            py1_reg <= point_y;
        end
    end

    // stage 2: edge vectors
    logic                 v2_reg;
    logic signed [DW-1:0] abx2_reg, aby2_reg, apx2_reg, apy2_reg;
    logic signed [C-1:0]  ax2_reg, ay2_reg, bx2_reg, by2_reg, px2_reg, py2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abx2_reg <= {bx1_reg[C-1], bx1_reg} - {ax1_reg[C-1], ax1_reg};
            aby2_reg <= {by1_reg[C-1], by1_reg} - {ay1_reg[C-1], ay1_reg};
            apx2_reg <= {px1_reg[C-1], px1_reg} - {ax1_reg[C-1], ax1_reg};
            apy2_reg <= {py1_reg[C-1], py1_reg} - {ay1_reg[C-1], ay1_reg};
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            bx2_reg  <= bx1_reg;
            by2_reg  <= by1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
        end
    end

    // stage 3: the four products
    logic                 v3_reg;
    logic signed [PW-1:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [DW-1:0] abx3_reg, aby3_reg;
    logic signed [C-1:0]  ax3_reg, ay3_reg, bx3_reg, by3_reg, px3_reg, py3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg   <= abx2_reg * apx2_reg;
            m1_reg   <= aby2_reg * apy2_reg;
            m2_reg   <= abx2_reg * abx2_reg;
            m3_reg   <= aby2_reg * aby2_reg;
            abx3_reg <= abx2_reg;
            aby3_reg <= aby2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
        end
    end

    // stage 4: dot, squared length and the region decision
    logic signed [DOT_W-1:0] dot3;
    logic [LEN_W-1:0]        len3;
    logic [DW-1:0]           magx3, magy3;
    logic [1:0]              part3;

    always_comb
    begin
        dot3  = {m0_reg[PW-1], m0_reg} + {m1_reg[PW-1], m1_reg};
        len3  = {1'b0, m2_reg[2*C-1:0]} + {1'b0, m3_reg[2*C-1:0]};
        magx3 = abx3_reg[DW-1] ? -abx3_reg : abx3_reg;
        magy3 = aby3_reg[DW-1] ? -aby3_reg : aby3_reg;
        if ((len3 == '0) || dot3[DOT_W-1])
            part3 = ptsd_pkg::PART_A;
        else if (dot3 > $signed({2'b00, len3}))
            part3 = ptsd_pkg::PART_B;
        else
            part3 = ptsd_pkg::PART_MID;
    end

    logic                v4_reg;
    logic [LEN_W-1:0]    dot4_reg, len4_reg;
    logic [C-1:0]        magx4_reg, magy4_reg;
    logic [SIDE_W-1:0]   side4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot4_reg  <= dot3[LEN_W-1:0];
            len4_reg  <= len3;
            magx4_reg <= magx3[C-1:0];
            magy4_reg <= magy3[C-1:0];
            side4_reg <= {part3, abx3_reg[DW-1], aby3_reg[DW-1],
                          ax3_reg, ay3_reg, bx3_reg, by3_reg, px3_reg, py3_reg};
        end
    end

    // stage 5: numerators dot*|ab|
    logic              v5_reg;
    logic [NW-1:0]     nx5_reg, ny5_reg;
    logic [LEN_W-1:0]  len5_reg;
    logic [SIDE_W-1:0] side5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg   <= dot4_reg * magx4_reg;
            ny5_reg   <= dot4_reg * magy4_reg;
            len5_reg  <= len4_reg;
            side5_reg <= side4_reg;
        end
    end

    // division chain, one quotient bit per cell
    logic                dv   [C+1];
    logic [LEN_W-1:0]    dd   [C+1];
    logic [RW-1:0]       drx  [C+1];
    logic [C-1:0]        dnx  [C+1];
    logic [RW-1:0]       dry  [C+1];
    logic [C-1:0]        dny  [C+1];
    logic [SIDE_W-1:0]   dside[C+1];

    assign dv[0]    = v5_reg;
    assign dd[0]    = len5_reg;
    assign drx[0]   = {1'b0, nx5_reg[NW-1:C]};
    assign dnx[0]   = nx5_reg[C-1:0];
    assign dry[0]   = {1'b0, ny5_reg[NW-1:C]};
    assign dny[0]   = ny5_reg[C-1:0];
    assign dside[0] = side5_reg;

    for (genvar i = 0; i < C; i++)
    begin : g_div
        ptsd_div_cell #(
            .RW     (RW),
            .QB     (C),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (dv[i]),
            .d_in     (dd[i]),
            .rx_in    (drx[i]),
            .nx_in    (dnx[i]),
            .ry_in    (dry[i]),
            .ny_in    (dny[i]),
            .side_in  (dside[i]),
            .v_out    (dv[i+1]),
            .d_out    (dd[i+1]),
            .rx_out   (drx[i+1]),
            .nx_out   (dnx[i+1]),
            .ry_out   (dry[i+1]),
            .ny_out   (dny[i+1]),
            .side_out (dside[i+1])
        );
    end

    // unpack side data after division
    logic [1:0]          fpart;
    logic                fnegx, fnegy;
    logic signed [C-1:0] fax, fay, fbx, fby, fpx, fpy;

    assign {fpart, fnegx, fnegy, fax, fay, fbx, fby, fpx, fpy} = dside[C];

    // projected point, truncated toward zero, then offset to the point
    logic signed [XW-1:0] qx, qy, bsx, bsy, tgx, tgy, dxn, dyn;
    logic                 inx, iny;

    always_comb
    begin
        inx = (drx[C] != '0);
        iny = (dry[C] != '0);
        qx  = $signed({2'b00, dnx[C]});
        qy  = $signed({2'b00, dny[C]});
        if (fnegx)
            qx = inx ? -(qx + XW'(1)) : -qx;
        if (fnegy)
            qy = iny ? -(qy + XW'(1)) : -qy;
        bsx = {{2{fax[C-1]}}, fax} + qx;
        bsy = {{2{fay[C-1]}}, fay} + qy;
        if (inx && bsx[XW-1])
            bsx = bsx + XW'(1);
        if (iny && bsy[XW-1])
            bsy = bsy + XW'(1);
        unique case (fpart)
            ptsd_pkg::PART_A:
            begin
                tgx = {{2{fax[C-1]}}, fax};
                tgy = {{2{fay[C-1]}}, fay};
            end
            ptsd_pkg::PART_B:
            begin
                tgx = {{2{fbx[C-1]}}, fbx};
                tgy = {{2{fby[C-1]}}, fby};
            end
            default:
            begin
                tgx = bsx;
                tgy = bsy;
            end
        endcase
        dxn = tgx - {{2{fpx[C-1]}}, fpx};
        dyn = tgy - {{2{fpy[C-1]}}, fpy};
    end

    logic                 v6_reg;
    logic signed [XW-1:0] dx6_reg, dy6_reg;
    logic [1:0]           part6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= dv[C];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx6_reg   <= dxn;
            dy6_reg   <= dyn;
            part6_reg <= fpart;
        end
    end

    // squares of the offsets
    logic          v7_reg;
    logic [SW-1:0] sx7_reg, sy7_reg;
    logic [1:0]    part7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx7_reg   <= SW'(dx6_reg * dx6_reg);
            sy7_reg   <= SW'(dy6_reg * dy6_reg);
            part7_reg <= part6_reg;
        end
    end

    // square root chain, one root bit per cell
    logic             sv   [RB+1];
    logic [RB+1:0]    srem [RB+1];
    logic [RAD_W-1:0] srad [RB+1];
    logic [RB-1:0]    sroot[RB+1];
    logic [1:0]       spart[RB+1];

    assign sv[0]    = v7_reg;
    assign srem[0]  = '0;
    assign srad[0]  = RAD_W'(sx7_reg + sy7_reg) << (2 * FRAC_BITS);
    assign sroot[0] = '0;
    assign spart[0] = part7_reg;

    for (genvar k = 0; k < RB; k++)
    begin : g_sqrt
        ptsd_sqrt_cell #(
            .RB (RB)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (sv[k]),
            .rem_in   (srem[k]),
            .rad_in   (srad[k]),
            .root_in  (sroot[k]),
            .part_in  (spart[k]),
            .v_out    (sv[k+1]),
            .rem_out  (srem[k+1]),
            .rad_out  (srad[k+1]),
            .root_out (sroot[k+1]),
            .part_out (spart[k+1])
        );
    end

    // the last cell is the output register
    assign out_valid    = sv[RB];
    assign distance     = ptsd_pkg::DIST_W'(sroot[RB]);
    assign nearest_part = spart[RB];

    // a result never carries the unused part code
    a_part_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (nearest_part == ptsd_pkg::PART_A ||
                       nearest_part == ptsd_pkg::PART_B ||
                       nearest_part == ptsd_pkg::PART_MID))
        else $error("invalid nearest part code");

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("stall without a held result");

    // a held result is still there in the next cycle
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> out_valid)
        else $error("held result lost");

endmodule
`default_nettype wire
